// File: hdl/uadh_pkg.sv
// Shared types and constants for the usage alarm with dwell hysteresis.
// Used by the divider, the top level and the port checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package uadh_pkg;

  // Full scale of a percentage.
  localparam logic [6:0] PCT_FULL = 7'd100;

  // Field widths fixed by the interface.
  localparam int SIZE_W = 32;
  localparam int PCT_W  = 7;
  localparam int TIME_W = 16;
  localparam int IVL_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Dividend is 100 * free, which needs 7 more bits than free.
  localparam int DVD_W    = SIZE_W + PCT_W;
  localparam int STEP_W   = $clog2(DVD_W);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAISE_PCT  = 3'd0,
    CFG_RAISE_TIME = 3'd1,
    CFG_CLEAR_PCT  = 3'd2,
    CFG_CLEAR_TIME = 3'd3,
    CFG_INTERVAL   = 3'd4
  } cfg_idx_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_COUNT,
    ST_PROD,
    ST_DONE
  } state_t;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] used;
  } div_res_t;

endpackage

`default_nettype wire

// File: hdl/uadh_div.sv
// Bit-serial restoring divider that turns free and total sizes into used percent.
// Depends on uadh_pkg for widths, the full-scale constant and the result struct.
`timescale 1ns / 1ps
`default_nettype none

module uadh_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [uadh_pkg::SIZE_W-1:0]   free_size,
  input  wire logic [uadh_pkg::SIZE_W-1:0]   total_size,
  output uadh_pkg::div_res_t                 res
);

  localparam int DVD_W  = uadh_pkg::DVD_W;
  localparam int SIZE_W = uadh_pkg::SIZE_W;
  localparam int PCT_W  = uadh_pkg::PCT_W;
  localparam int STEP_W = uadh_pkg::STEP_W;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DVD_W - 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [DVD_W-1:0]  dvd;
  logic [SIZE_W-1:0] dsr;
  logic [SIZE_W-1:0] rem;
  logic [PCT_W-1:0]  quo;
  logic              ovf;

  logic [SIZE_W:0]   trial;
  logic [SIZE_W:0]   diff;
  logic              fits;
  logic              sat;

  // One quotient bit per cycle: shift the next dividend bit into the remainder.
  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    diff  = trial - {1'b0, dsr};
    fits  = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= DVD_W'(free_size) * DVD_W'(uadh_pkg::PCT_FULL);
      dsr  <= total_size;
      rem  <= '0;
      quo  <= '0;
      ovf  <= 1'b0;
      step <= STEP_LAST;
    end else if (busy) begin
      rem  <= fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
      dvd  <= {dvd[DVD_W-2:0], 1'b0};
      quo  <= {quo[PCT_W-2:0], fits};
      // A set bit leaving the top of the quotient means the free percent is above 127.
      ovf  <= ovf | quo[PCT_W-1];
      step <= step - 1'b1;
    end
  end

  always_comb begin
    sat      = ovf || (quo >= uadh_pkg::PCT_FULL);
    res.done = done;
    res.used = sat ? '0 : (uadh_pkg::PCT_FULL - quo);
  end

endmodule

`default_nettype wire

// File: hdl/usage_alarm_with_dwell_hysteresis_top.sv
// Path: a nonzero total runs the 39-step divide (ST_DIV), then ST_COUNT and, except for the
// first such sample after reset, ST_PROD for the dwell product, before ST_DONE; a zero
// total goes straight to ST_DONE. One sample at a time: the next is taken once the block is
// back in idle, and a finished result waiting in the output register does not hold it off.
// Reset (rst, synchronous, active high) restores the register defaults, marks the first
// sample as pending, returns the alarm to normal and clears the run counter.
`timescale 1ns / 1ps
`default_nettype none

module usage_alarm_with_dwell_hysteresis_top #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Sample channel.
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [uadh_pkg::SIZE_W-1:0]       free_size,
  input  wire logic [uadh_pkg::SIZE_W-1:0]       total_size,
  // Result channel.
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [uadh_pkg::PCT_W-1:0]             used_percent,
  output logic                                   overloaded,
  output logic                                   raise_event,
  output logic                                   clear_event,
  output logic                                   evaluated,
  output logic                                   total_zero,
  // Configuration write channel.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [uadh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [uadh_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int PCT_W  = uadh_pkg::PCT_W;
  localparam int TIME_W = uadh_pkg::TIME_W;
  localparam int IVL_W  = uadh_pkg::IVL_W;
  // The dwell product is the run count times the sample interval.
  localparam int PROD_W = COUNT_BITS + IVL_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration registers.
  logic [PCT_W-1:0]  raise_percent;
  logic [TIME_W-1:0] raise_time;
  logic [PCT_W-1:0]  clear_percent;
  logic [TIME_W-1:0] clear_time;
  logic [IVL_W-1:0]  sample_interval;

  // Alarm state.
  logic                  first_pending;
  logic                  overload_state;
  logic [COUNT_BITS-1:0] run_count;

  // Per-sample working registers.
  uadh_pkg::state_t      state;
  uadh_pkg::state_t      state_next;
  logic [PCT_W-1:0]      used_r;
  logic                  eval_r;
  logic                  tz_r;
  logic [PROD_W-1:0]     prod;

  logic                  in_xfer;
  logic                  div_start;
  logic                  out_free;
  logic                  cond;
  logic                  hit;
  logic [TIME_W-1:0]     need;
  uadh_pkg::div_res_t    div_res;

  // Always takes a write; the user must make writes only while the block is idle, unchecked.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      raise_percent   <= PCT_W'(80);
      raise_time      <= TIME_W'(60);
      clear_percent   <= PCT_W'(60);
      clear_time      <= TIME_W'(60);
      sample_interval <= IVL_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        uadh_pkg::CFG_RAISE_PCT:  raise_percent   <= cfg_data[PCT_W-1:0];
        uadh_pkg::CFG_RAISE_TIME: raise_time      <= cfg_data[TIME_W-1:0];
        uadh_pkg::CFG_CLEAR_PCT:  clear_percent   <= cfg_data[PCT_W-1:0];
        uadh_pkg::CFG_CLEAR_TIME: clear_time      <= cfg_data[TIME_W-1:0];
        uadh_pkg::CFG_INTERVAL:   sample_interval <= cfg_data[IVL_W-1:0];
        default: ;
      endcase
    end
  end

  // A sample transfer happens only in idle. A zero total skips the divider entirely.
  assign in_stall  = (state != uadh_pkg::ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign div_start = in_xfer && (total_size != '0);

  // The output register can take a new result when empty or being drained this cycle.
  assign out_free  = !out_valid || !out_stall;

  uadh_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .free_size  (free_size),
    .total_size (total_size),
    .res        (div_res)
  );

  // While normal the counter runs on high usage; while overloaded it runs on low usage.
  // Thresholds above 100 fall out naturally from the 7-bit compares.
  always_comb begin
    cond = overload_state ? (used_r < clear_percent) : (used_r >= raise_percent);
    need = overload_state ? clear_time : raise_time;
    hit  = eval_r && (prod >= PROD_W'(need));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uadh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      uadh_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_next = (total_size == '0) ? uadh_pkg::ST_DONE : uadh_pkg::ST_DIV;
        end
      end
      uadh_pkg::ST_DIV: begin
        if (div_res.done) begin
          state_next = uadh_pkg::ST_COUNT;
        end
      end
      uadh_pkg::ST_COUNT: begin
        state_next = first_pending ? uadh_pkg::ST_DONE : uadh_pkg::ST_PROD;
      end
      uadh_pkg::ST_PROD: begin
        state_next = uadh_pkg::ST_DONE;
      end
      uadh_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = uadh_pkg::ST_IDLE;
        end
      end
      default: state_next = uadh_pkg::ST_IDLE;
    endcase
  end

  // Alarm state: the first nonzero-total sample only clears the pending flag; later ones
  // update the run counter, and the dwell test commits together with the result transfer
  // into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending  <= 1'b1;
      overload_state <= 1'b0;
      run_count      <= '0;
    end else begin
      if (state == uadh_pkg::ST_COUNT) begin
        if (first_pending) begin
          first_pending <= 1'b0;
        end else if (cond) begin
          if (run_count != CNT_MAX) begin
            run_count <= run_count + 1'b1;
          end
        end else begin
          run_count <= '0;
        end
      end
      if (state == uadh_pkg::ST_DONE && out_free && hit) begin
        run_count      <= '0;
        overload_state <= !overload_state;
      end
    end
  end

  // Working registers for the sample in flight.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      used_r <= '0;
      eval_r <= 1'b0;
      tz_r   <= (total_size == '0);
    end
    if (state == uadh_pkg::ST_DIV && div_res.done) begin
      used_r <= div_res.used;
    end
    if (state == uadh_pkg::ST_COUNT) begin
      eval_r <= !first_pending;
    end
    if (state == uadh_pkg::ST_PROD) begin
      prod <= PROD_W'(run_count) * PROD_W'(sample_interval);
    end
  end

  // Output register: holds a finished result until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == uadh_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == uadh_pkg::ST_DONE && out_free) begin
      used_percent <= used_r;
      overloaded   <= overload_state ^ hit;
      raise_event  <= hit && !overload_state;
      clear_event  <= hit && overload_state;
      evaluated    <= eval_r;
      total_zero   <= tz_r;
    end
  end

endmodule

`default_nettype wire

// File: hdl/uadh_chk.sv
// Port-level checker for the usage alarm; attached to the top level by the bind below.
// Depends on uadh_pkg for field widths and the full-scale constant.
`timescale 1ns / 1ps
`default_nettype none

module uadh_chk (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            out_valid,
  input wire logic [uadh_pkg::PCT_W-1:0]      used_percent,
  input wire logic                            overloaded,
  input wire logic                            raise_event,
  input wire logic                            clear_event,
  input wire logic                            evaluated,
  input wire logic                            total_zero
);

  // A zero total is ignored: no percent, no evaluation, no events.
  a_zero_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && total_zero |->
      used_percent == '0 && !evaluated && !raise_event && !clear_event)
    else $error("zero-total result carries data or events");

  // Events only come from evaluated samples, and never both at once.
  a_event_eval: assert property (@(posedge clk) disable iff (rst)
    out_valid && (raise_event || clear_event) |-> evaluated && !(raise_event && clear_event))
    else $error("event without evaluation or both events set");

  // An event and the reported alarm state agree.
  a_event_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!raise_event || overloaded) && (!clear_event || !overloaded))
    else $error("event disagrees with alarm state");

  // Used percent never exceeds full scale.
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> used_percent <= uadh_pkg::PCT_FULL)
    else $error("used percent above 100");

endmodule

bind usage_alarm_with_dwell_hysteresis_top uadh_chk u_uadh_chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .used_percent (used_percent),
  .overloaded   (overloaded),
  .raise_event  (raise_event),
  .clear_event  (clear_event),
  .evaluated    (evaluated),
  .total_zero   (total_zero)
);

`default_nettype wire
